// ===== src/ptts_pkg.sv =====
// shared types and constants for the periodic task tick scheduler
package ptts_pkg;

    localparam int TASK_W  = 2;
    localparam int SLOT_W  = 16;
    localparam int TABLE_W = 64;
    localparam int ADDR_W  = 4;

    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_SUSPEND = 2'd1;
    localparam logic [1:0] ACT_START   = 2'd2;

    localparam logic REG_PERIOD = 1'b0;
    localparam logic REG_DELAY  = 1'b1;

    typedef struct packed {
        logic [1:0]        action;
        logic [TASK_W-1:0] task_index;
    } t_in_word;

    typedef struct packed {
        logic [TASK_W-1:0] fired_task;
        logic              last;
    } t_out_word;

    typedef struct packed {
        logic start;
        logic suspend;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic fire;
        logic slot_free;
        logic walk_end;
    } t_dp_status;

endpackage

// ===== src/ptts_ctrl.sv =====
// controller state machine: accepts words and sequences the task walk
module ptts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic [1:0]            i_action,
    input  ptts_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output ptts_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_ctl_state;

    t_ctl_state r_state;
    t_ctl_state n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.start   = accept && (i_action == ptts_pkg::ACT_START);
        o_cmd.suspend = accept && (i_action == ptts_pkg::ACT_SUSPEND);
        // a firing task waits until the output register can take its word
        o_cmd.step    = (r_state == S_WALK) && (!i_status.fire || i_status.slot_free);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ptts_pkg::ACT_TICK)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (o_cmd.step && i_status.walk_end) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/ptts_datapath.sv =====
// datapath: tables, countdowns, running flags, walk index and output register
module ptts_datapath #(
    parameter int NUM_TASKS   = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ptts_pkg::t_dp_cmd              i_cmd,
    input  ptts_pkg::t_in_word             i_in_data,
    input  logic                           i_out_ready,
    input  logic                           i_cfg_we,
    input  logic                           i_cfg_sel,
    input  logic [ptts_pkg::TABLE_W-1:0]   i_cfg_wdata,
    output logic [ptts_pkg::TABLE_W-1:0]   o_cfg_rdata,
    output ptts_pkg::t_dp_status           o_status,
    output logic                           o_out_valid,
    output ptts_pkg::t_out_word            o_out_data
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = IDX_W + 1;

    logic [ptts_pkg::TABLE_W-1:0] r_period_table;
    logic [ptts_pkg::TABLE_W-1:0] r_delay_table;
    logic [COUNT_WIDTH-1:0]       r_count [NUM_TASKS];
    logic [NUM_TASKS-1:0]         r_running;
    logic [IDX_W-1:0]             r_walk;
    logic                         r_out_valid;
    ptts_pkg::t_out_word          r_out_data;

    logic [COUNT_WIDTH-1:0] period_slot [NUM_TASKS];
    logic [COUNT_WIDTH-1:0] delay_slot  [NUM_TASKS];
    logic [NUM_TASKS-1:0]   fire_vec;
    logic                   later_fire;
    logic                   walk_end;
    logic                   susp_ok;
    logic [IDX_W-1:0]       susp_idx;

    for (genvar g = 0; g < NUM_TASKS; g++) begin : g_slot
        assign period_slot[g] = r_period_table[ptts_pkg::SLOT_W*g +: COUNT_WIDTH];
        assign delay_slot[g]  = r_delay_table[ptts_pkg::SLOT_W*g +: COUNT_WIDTH];
        assign fire_vec[g]    = (r_count[g] == '0) && r_running[g];
    end

    // tasks above the walk index are untouched until their turn; flag any that fires
    always_comb begin
        later_fire = 1'b0;
        for (int j = 0; j < NUM_TASKS; j++) begin
            if (j > int'(r_walk)) begin
                later_fire = later_fire | fire_vec[j];
            end
        end
    end

    assign walk_end = (r_walk == IDX_W'(NUM_TASKS - 1));
    assign susp_ok  = ({1'b0, i_in_data.task_index} < (ptts_pkg::TASK_W + 1)'(NUM_TASKS));
    assign susp_idx = i_in_data.task_index[IDX_W-1:0];

    always_comb begin
        o_status.fire      = fire_vec[r_walk];
        o_status.slot_free = !r_out_valid || i_out_ready;
        o_status.walk_end  = walk_end;
    end

    assign o_cfg_rdata = (i_cfg_sel == ptts_pkg::REG_DELAY) ? r_delay_table : r_period_table;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_table <= '0;
            r_delay_table  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_sel == ptts_pkg::REG_DELAY) begin
                r_delay_table <= i_cfg_wdata;
            end else begin
                r_period_table <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TASKS; k++) begin
                r_count[k] <= '0;
            end
            r_running <= '1;
            r_walk    <= '0;
        end else begin
            if (i_cmd.start) begin
                for (int k = 0; k < NUM_TASKS; k++) begin
                    r_count[k] <= delay_slot[k];
                end
                r_running <= '1;
            end
            if (i_cmd.suspend && susp_ok) begin
                r_running[susp_idx] <= 1'b0;
            end
            if (i_cmd.step) begin
                // suspended task at zero holds instead of wrapping
                if (r_count[r_walk] == '0) begin
                    if (r_running[r_walk]) begin
                        r_count[r_walk] <= period_slot[r_walk];
                    end
                end else begin
                    r_count[r_walk] <= r_count[r_walk] - COUNT_WIDTH'(1);
                end
                r_walk <= walk_end ? '0 : IDX_W'(CNT_W'(r_walk) + CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && fire_vec[r_walk]) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && fire_vec[r_walk]) begin
            r_out_data.fired_task <= ptts_pkg::TASK_W'(r_walk);
            r_out_data.last       <= !later_fire;
        end
    end

endmodule

// ===== src/periodic_task_tick_scheduler_unit.sv =====
// top level of the periodic task tick scheduler
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_data) takes one word per
//   command: tick, suspend of one task, or start (reload delays, all running).
//   output channel (o_out_valid / i_out_ready / o_out_data) gives one word per
//   task that fires on a tick, in task order, with last set on the final one.
//   a tick that fires nothing gives no word.
//   config port: period_table at byte address 0, delay_table at 8, 64 bits
//   each, written during the access cycle; pready is always high.
// timing:
//   start and suspend take effect in the accept cycle; the next word can be
//   taken in the cycle after. a tick walks the countdowns one task per cycle
//   while no firing task is held by the output register; fired words
//   appear in the cycle after their step. each walk step updates only the
//   countdown at the walk index.
// reset: countdowns go to zero, all tasks running, both tables zero.
// stall: a firing task waits while the output register holds an untaken word;
//   no input word is taken until the walk ends.
module periodic_task_tick_scheduler_unit #(
    parameter int NUM_TASKS   = 4,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ptts_pkg::t_in_word             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ptts_pkg::t_out_word            o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ptts_pkg::ADDR_W-1:0]    paddr,
    input  logic [ptts_pkg::TABLE_W-1:0]   pwdata,
    output logic [ptts_pkg::TABLE_W-1:0]   prdata,
    output logic                           pready
);

    ptts_pkg::t_dp_cmd    cmd;
    ptts_pkg::t_dp_status status;
    logic                 cfg_we;
    logic                 cfg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_sel = paddr[3];

    ptts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ptts_datapath #(
        .NUM_TASKS   (NUM_TASKS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (cfg_we),
        .i_cfg_sel   (cfg_sel),
        .i_cfg_wdata (pwdata),
        .o_cfg_rdata (prdata),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
